>>> src/tte_pkg.sv
// tte_pkg: shared codes, geometry and result types for the tiled texel encoder
// no dependencies; imported by tte_pack and tiled_texel_encoder
`default_nettype none

package tte_pkg;

  // texture format codes
  localparam logic [3:0] FMT_I4     = 4'd0;
  localparam logic [3:0] FMT_I8     = 4'd1;
  localparam logic [3:0] FMT_IA4    = 4'd2;
  localparam logic [3:0] FMT_IA8    = 4'd3;
  localparam logic [3:0] FMT_RGB565 = 4'd4;
  localparam logic [3:0] FMT_RGB5A3 = 4'd5;
  localparam logic [3:0] FMT_RGBA8  = 4'd6;
  localparam logic [3:0] FMT_CI4    = 4'd8;
  localparam logic [3:0] FMT_CI8    = 4'd9;

  // palette entry format codes
  localparam logic [1:0] PAL_IA8    = 2'd0;
  localparam logic [1:0] PAL_RGB565 = 2'd1;
  localparam logic [1:0] PAL_RGB5A3 = 2'd2;

  // write kinds
  localparam logic [1:0] KIND_HI_NIB = 2'd0;
  localparam logic [1:0] KIND_LO_NIB = 2'd1;
  localparam logic [1:0] KIND_BYTE   = 2'd2;
  localparam logic [1:0] KIND_TWO    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_TEX_FMT = 2'd0;
  localparam logic [1:0] REG_IMG_W   = 2'd1;
  localparam logic [1:0] REG_PAL_FMT = 2'd2;

  localparam int unsigned ImgWBits = 11;

  // tile geometry: 8x8, 8x4, 4x4 of 32 bytes, 4x4 of 64 bytes
  typedef enum logic [1:0] {
    GEO_8X8,
    GEO_8X4,
    GEO_4X4,
    GEO_4X4_64
  } geo_t;

  // packed pixel and its control flags
  typedef struct packed {
    logic [15:0] data;   // first (or only) beat
    logic [15:0] data2;  // green/blue half of rgba8
    logic [1:0]  kind;
    logic        err;
    logic        pair;   // two beats
    logic        pal;    // palette entry address
    geo_t        geo;
  } pack_t;

endpackage

`default_nettype wire

>>> src/tte_pack.sv
// tte_pack: converts one rgba pixel to its texel or palette encoding
// depends on tte_pkg
`default_nettype none

module tte_pack (
  input  wire logic         func,
  input  wire logic [3:0]   tex_fmt,
  input  wire logic [1:0]   pal_fmt,
  input  wire logic         x_lsb,
  input  wire logic [7:0]   red,
  input  wire logic [7:0]   green,
  input  wire logic [7:0]   blue,
  input  wire logic [7:0]   alpha,
  output tte_pkg::pack_t    pk
);
  import tte_pkg::*;

  logic [15:0] v565;
  logic [15:0] v5a3;
  logic [15:0] via8;

  always_comb begin
    v565 = {red[7:3], green[7:2], blue[7:3]};
    if (alpha == 8'hff) begin
      v5a3 = {1'b1, red[7:3], green[7:3], blue[7:3]};
    end else begin
      v5a3 = {1'b0, alpha[7:5], red[7:4], green[7:4], blue[7:4]};
    end
    via8 = {alpha, red};
  end

  always_comb begin
    pk       = '0;
    pk.geo   = GEO_4X4;
    pk.kind  = KIND_TWO;
    pk.data2 = {green, blue};
    if (func) begin
      pk.pal = 1'b1;
      case (pal_fmt)
        PAL_IA8:    pk.data = via8;
        PAL_RGB565: pk.data = v565;
        PAL_RGB5A3: pk.data = v5a3;
        default: begin
          pk.err  = 1'b1;
          pk.kind = KIND_HI_NIB;
        end
      endcase
    end else begin
      case (tex_fmt)
        FMT_I4, FMT_CI4: begin
          pk.geo  = GEO_8X8;
          pk.kind = x_lsb ? KIND_LO_NIB : KIND_HI_NIB;
          pk.data = (tex_fmt == FMT_I4) ? {12'd0, red[7:4]} : {12'd0, red[3:0]};
        end
        FMT_I8, FMT_CI8: begin
          pk.geo  = GEO_8X4;
          pk.kind = KIND_BYTE;
          pk.data = {8'd0, red};
        end
        FMT_IA4: begin
          pk.geo  = GEO_8X4;
          pk.kind = KIND_BYTE;
          pk.data = {8'd0, alpha[7:4], red[7:4]};
        end
        FMT_IA8:    pk.data = via8;
        FMT_RGB565: pk.data = v565;
        FMT_RGB5A3: pk.data = v5a3;
        FMT_RGBA8: begin
          pk.geo  = GEO_4X4_64;
          pk.data = via8;
          pk.pair = 1'b1;
        end
        default: begin
          pk.err  = 1'b1;
          pk.kind = KIND_HI_NIB;
        end
      endcase
    end
    if (pk.err) begin
      pk.data2 = '0;
    end
  end

endmodule

`default_nettype wire

>>> src/tiled_texel_encoder.sv
// tiled_texel_encoder: top level, tile address pipeline and output beat control
// depends on tte_pkg and tte_pack
`default_nettype none

// channel  dir  handshake           payload
// in_      in   in_valid/in_stall   func pos_x pos_y palette_slot red green blue alpha
// out_     out  out_valid/out_stall byte_addr write_data write_kind format_error last
// cfg_     in   cfg_valid/cfg_ready index (0 fmt, 1 width, 2 palette fmt) data
//
// one item enters per cycle while in_stall is low, through three register stages:
// stage 1, stage 2, output; rgba8 items hold the output stage for both of two beats
// the multiplier stage (tile row times tiles per row) sets the stage depth
// synchronous reset clears valid bits and config to its defaults (rgb565, width 1024)
// a stalled output freezes the pipeline from the back; empty stages still fill
// the user must make writes only while no item is in flight; the block does not
// enforce this, and the config port is always ready

module tiled_texel_encoder #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input beats
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [9:0]  in_pos_x,
  input  wire logic [9:0]  in_pos_y,
  input  wire logic [7:0]  in_palette_slot,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_alpha,
  // result beats
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [21:0]      out_byte_addr,
  output logic [15:0]      out_write_data,
  output logic [1:0]       out_write_kind,
  output logic             out_format_error,
  output logic             out_last,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  import tte_pkg::*;

  // config registers
  logic [3:0]          tex_fmt_r;
  logic [ImgWBits-1:0] img_w_r;
  logic [1:0]          pal_fmt_r;

  // stage 1: packed pixel and tile coordinates
  logic        s1_v_r, s1_v_nxt;
  pack_t       s1_pk_r;
  logic [7:0]  s1_row_r;
  logic [7:0]  s1_col_r;
  logic [9:0]  s1_tpr_r;
  logic [4:0]  s1_off_r;
  logic [7:0]  s1_slot_r;

  // stage 2: row times tiles per row
  logic        s2_v_r, s2_v_nxt;
  pack_t       s2_pk_r;
  logic [17:0] s2_prod_r;
  logic [7:0]  s2_col_r;
  logic [4:0]  s2_off_r;
  logic [7:0]  s2_slot_r;

  // output stage
  logic        out_v_r, out_v_nxt;
  logic        second_r, second_nxt;
  logic [21:0] addr_r;
  logic [15:0] data_r;
  logic [15:0] data2_r;
  logic [1:0]  kind_r;
  logic        err_r;
  logic        pair_r;

  // stage enables, taken from the back
  logic en_out, en_s2, en_s1;
  logic out_take;

  pack_t                pk;
  logic                 w_over;
  logic [ImgWBits-1:0]  w_eff;
  logic [9:0]           tpr8, tpr4;
  logic [7:0]           row_c, col_c;
  logic [9:0]           tpr_c;
  logic [4:0]           off_c;
  logic [18:0]          tile_c;
  logic [21:0]          addr_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_fmt_r <= FMT_RGB565;
      img_w_r   <= ImgWBits'(1024);
      pal_fmt_r <= PAL_IA8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEX_FMT: tex_fmt_r <= cfg_data[3:0];
        REG_IMG_W:   img_w_r   <= cfg_data;
        REG_PAL_FMT: pal_fmt_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  tte_pack u_pack (
    .func    (in_func),
    .tex_fmt (tex_fmt_r),
    .pal_fmt (pal_fmt_r),
    .x_lsb   (in_pos_x[0]),
    .red     (in_red),
    .green   (in_green),
    .blue    (in_blue),
    .alpha   (in_alpha),
    .pk      (pk)
  );

  // beat control: output stage frees once its last beat is taken
  always_comb begin
    out_take   = out_v_r && !out_stall;
    en_out     = !out_v_r || (out_take && (!pair_r || second_r));
    en_s2      = !s2_v_r || en_out;
    en_s1      = !s1_v_r || en_s2;
    in_stall   = !en_s1;
    s1_v_nxt   = en_s1 ? in_valid : s1_v_r;
    s2_v_nxt   = en_s2 ? s1_v_r : s2_v_r;
    out_v_nxt  = en_out ? s2_v_r : out_v_r;
    second_nxt = out_take ? (pair_r && !second_r) : second_r;
  end

  // tiles per row from the clamped width
  always_comb begin
    w_over = {2'b00, img_w_r} > 13'(MAX_WIDTH);
    w_eff  = w_over ? ImgWBits'(MAX_WIDTH) : img_w_r;
    tpr8   = 10'(({1'b0, w_eff} + 12'd7) >> 3);
    tpr4   = 10'(({1'b0, w_eff} + 12'd3) >> 2);
  end

  // tile coordinates and place inside the tile
  always_comb begin
    case (pk.geo)
      GEO_8X8: begin
        row_c = {1'b0, in_pos_y[9:3]};
        col_c = {1'b0, in_pos_x[9:3]};
        tpr_c = tpr8;
        off_c = {in_pos_y[2:0], in_pos_x[2:1]};
      end
      GEO_8X4: begin
        row_c = in_pos_y[9:2];
        col_c = {1'b0, in_pos_x[9:3]};
        tpr_c = tpr8;
        off_c = {in_pos_y[1:0], in_pos_x[2:0]};
      end
      default: begin
        row_c = in_pos_y[9:2];
        col_c = in_pos_x[9:2];
        tpr_c = tpr4;
        off_c = {in_pos_y[1:0], in_pos_x[1:0], 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      s1_v_r   <= s1_v_nxt;
      s2_v_r   <= s2_v_nxt;
      out_v_r  <= out_v_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_pk_r   <= pk;
      s1_row_r  <= row_c;
      s1_col_r  <= col_c;
      s1_tpr_r  <= tpr_c;
      s1_off_r  <= off_c;
      s1_slot_r <= in_palette_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      s2_pk_r   <= s1_pk_r;
      s2_prod_r <= 18'(s1_row_r) * 18'(s1_tpr_r);
      s2_col_r  <= s1_col_r;
      s2_off_r  <= s1_off_r;
      s2_slot_r <= s1_slot_r;
    end
  end

  // tile base is a multiple of the tile size, so the offset goes in by concatenation
  always_comb begin
    tile_c = 19'(s2_prod_r) + 19'(s2_col_r);
    if (s2_pk_r.err) begin
      addr_c = '0;
    end else if (s2_pk_r.pal) begin
      addr_c = 22'({s2_slot_r, 1'b0});
    end else if (s2_pk_r.geo == GEO_4X4_64) begin
      addr_c = 22'({tile_c, 1'b0, s2_off_r});
    end else begin
      addr_c = 22'({tile_c, s2_off_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      addr_r  <= addr_c;
      data_r  <= s2_pk_r.data;
      data2_r <= s2_pk_r.data2;
      kind_r  <= s2_pk_r.kind;
      err_r   <= s2_pk_r.err;
      pair_r  <= s2_pk_r.pair;
    end
  end

  // second rgba8 beat sits 32 bytes on: bit 5 of a 64-byte tile base is clear
  assign out_valid        = out_v_r;
  assign out_byte_addr    = second_r ? (addr_r | 22'd32) : addr_r;
  assign out_write_data   = second_r ? data2_r : data_r;
  assign out_write_kind   = kind_r;
  assign out_format_error = err_r;
  assign out_last         = !pair_r || second_r;

  // second beat only ever follows a two-beat item in the output stage
  a_second_pair: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> (out_v_r && pair_r))
    else $error("second beat without a two-beat item");

  // taking the first beat of a pair leaves the second, final one showing
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && pair_r && !second_r) |=> (out_v_r && second_r && out_last))
    else $error("second beat of pair lost");

  // error beats carry nothing to write
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && err_r) |-> (out_byte_addr == 22'd0 && out_write_data == 16'd0 && out_last))
    else $error("error beat carries data");

  // input stalls only while stage 1, stage 2 and the output stage are all full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && out_v_r))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
